/* hdl/abs_pkg.sv */
`default_nettype none
package abs_pkg;

   localparam int MaxBytes     = 20;
   localparam int PAYLOAD_BYTES = 20;
   localparam int PayloadBits  = 8 * MaxBytes;
   localparam int SumBits      = 13;
   localparam int AckSumBits   = 22;
   localparam int FieldBits    = 20;

   localparam logic [6:0] SEND_ACK_CODE = 7'd111;

   typedef enum logic [1:0] {
      FUNC_MESSAGE = 2'd0,
      FUNC_ACK     = 2'd1,
      FUNC_TIMEOUT = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      ST_SENT         = 3'd0,
      ST_DROPPED_BUSY = 3'd1,
      ST_ACK_CORRUPT  = 3'd2,
      ST_ACK_UNEXPECT = 3'd3,
      ST_ACK_ACCEPTED = 3'd4,
      ST_RESENT       = 3'd5,
      ST_IDLE_TIMEOUT = 3'd6
   } status_type;

   typedef struct packed {
      logic [1:0]             func;
      logic [PayloadBits-1:0] payload;
      logic [FieldBits-1:0]   ack_seq_field;
      logic [FieldBits-1:0]   ack_number;
      logic [AckSumBits-1:0]  ack_sum;
   } req_item_type;

   typedef struct packed {
      logic                   send_valid;
      logic                   send_seq;
      logic [6:0]             send_ack_field;
      logic [SumBits-1:0]     send_sum;
      logic [PayloadBits-1:0] send_payload;
      logic                   timer_start;
      logic                   timer_stop;
      status_type             status;
   } rsp_item_type;

   // keep only the bytes that take part in the transfer
   function automatic logic [PayloadBits-1:0] mask_payload(input logic [PayloadBits-1:0] p);
      logic [PayloadBits-1:0] m;
      m = '0;
      for (int i = 0; i < MaxBytes; i++) begin
         if (i < PAYLOAD_BYTES) begin
            m[8*i +: 8] = p[8*i +: 8];
         end
      end
      return m;
   endfunction

   // adder tree over the payload bytes: four partial sums, then combine
   function automatic logic [SumBits-1:0] byte_sum(input logic [PayloadBits-1:0] p);
      logic [10:0] part [4];
      logic [SumBits-1:0] total;
      for (int g = 0; g < 4; g++) begin
         part[g] = 11'(p[8*(5*g)   +: 8]) + 11'(p[8*(5*g+1) +: 8])
                 + 11'(p[8*(5*g+2) +: 8]) + 11'(p[8*(5*g+3) +: 8])
                 + 11'(p[8*(5*g+4) +: 8]);
      end
      total = (SumBits'(part[0]) + SumBits'(part[1])) + (SumBits'(part[2]) + SumBits'(part[3]));
      return total;
   endfunction

endpackage
`default_nettype wire

/* hdl/alternating_bit_sender.sv */
`default_nettype none
// Alternating-bit sender: one event in, one result out.
// An accepted event is held in the input register; its result is registered in the result register.
// Throughput: one event per cycle; the input register and the result register
// advance together, so the only limit is the stall from the result side.
// Reset (synchronous, active high) clears busy, the sequence bit and both valids;
// the held packet is undefined until the first message is taken.
module alternating_bit_sender import abs_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [1:0]   req_func,
   input  wire logic [63:0]  req_payload_w0,
   input  wire logic [63:0]  req_payload_w1,
   input  wire logic [31:0]  req_payload_w2,
   input  wire logic [19:0]  req_ack_seq_field,
   input  wire logic [19:0]  req_ack_number,
   input  wire logic [21:0]  req_ack_sum,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic              rsp_send_valid,
   output logic              rsp_send_seq,
   output logic [6:0]        rsp_send_ack_field,
   output logic [12:0]       rsp_send_sum,
   output logic [63:0]       rsp_send_w0,
   output logic [63:0]       rsp_send_w1,
   output logic [31:0]       rsp_send_w2,
   output logic              rsp_timer_start,
   output logic              rsp_timer_stop,
   output logic [2:0]        rsp_status
);

   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type result;
   logic         out_free;
   logic         s1_fire;
   logic         accept;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign s1_fire      = s1_valid_ff && out_free;
   assign req_stall    = s1_valid_ff && !out_free;
   assign accept       = req_valid && !req_stall;
   assign s1_valid_in  = accept || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff.func          <= req_func;
         s1_item_ff.payload       <= {req_payload_w2, req_payload_w1, req_payload_w0};
         s1_item_ff.ack_seq_field <= req_ack_seq_field;
         s1_item_ff.ack_number    <= req_ack_number;
         s1_item_ff.ack_sum       <= req_ack_sum;
      end
   end

   abs_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (s1_fire),
      .item   (s1_item_ff),
      .result (result)
   );

   // hold the result until the transfer completes
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_send_valid     = rsp_item_ff.send_valid;
   assign rsp_send_seq       = rsp_item_ff.send_seq;
   assign rsp_send_ack_field = rsp_item_ff.send_ack_field;
   assign rsp_send_sum       = rsp_item_ff.send_sum;
   assign rsp_send_w0        = rsp_item_ff.send_payload[63:0];
   assign rsp_send_w1        = rsp_item_ff.send_payload[127:64];
   assign rsp_send_w2        = rsp_item_ff.send_payload[159:128];
   assign rsp_timer_start    = rsp_item_ff.timer_start;
   assign rsp_timer_stop     = rsp_item_ff.timer_stop;
   assign rsp_status         = rsp_item_ff.status;

endmodule
`default_nettype wire

/* hdl/abs_engine.sv */
`default_nettype none
module abs_engine import abs_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         fire,
   input  wire req_item_type item,
   output rsp_item_type      result
);

   logic                   busy_ff, busy_in;
   logic                   seq_ff, seq_in;
   logic [PayloadBits-1:0] held_payload_ff, held_payload_in;
   logic [SumBits-1:0]     held_sum_ff, held_sum_in;

   logic [PayloadBits-1:0] payload;
   logic [SumBits-1:0]     psum;
   logic [AckSumBits-1:0]  ack_calc;
   logic                   ack_match;

   always_comb begin
      payload   = mask_payload(item.payload);
      psum      = byte_sum(payload);
      ack_calc  = AckSumBits'(psum) + AckSumBits'(item.ack_seq_field)
                + AckSumBits'(item.ack_number);
      ack_match = (item.ack_number == FieldBits'(seq_ff));

      busy_in         = busy_ff;
      seq_in          = seq_ff;
      held_payload_in = held_payload_ff;
      held_sum_in     = held_sum_ff;
      result          = '0;
      result.status   = ST_IDLE_TIMEOUT;

      case (item.func)
         FUNC_MESSAGE: begin
            if (busy_ff) begin
               result.status = ST_DROPPED_BUSY;
            end else begin
               held_payload_in       = payload;
               held_sum_in           = psum + SumBits'(seq_ff) + SumBits'(SEND_ACK_CODE);
               busy_in               = 1'b1;
               result.send_valid     = 1'b1;
               result.send_seq       = seq_ff;
               result.send_ack_field = SEND_ACK_CODE;
               result.send_sum       = held_sum_in;
               result.send_payload   = payload;
               result.timer_start    = 1'b1;
               result.status         = ST_SENT;
            end
         end
         FUNC_ACK: begin
            if (ack_calc != item.ack_sum) begin
               result.status = ST_ACK_CORRUPT;
            end else if (!busy_ff || !ack_match) begin
               result.status = ST_ACK_UNEXPECT;
            end else begin
               seq_in            = ~seq_ff;
               busy_in           = 1'b0;
               result.timer_stop = 1'b1;
               result.status     = ST_ACK_ACCEPTED;
            end
         end
         FUNC_TIMEOUT: begin
            if (busy_ff) begin
               result.send_valid     = 1'b1;
               result.send_seq       = seq_ff;
               result.send_ack_field = SEND_ACK_CODE;
               result.send_sum       = held_sum_ff;
               result.send_payload   = held_payload_ff;
               result.timer_start    = 1'b1;
               result.status         = ST_RESENT;
            end
         end
         default: begin
            result.status = ST_IDLE_TIMEOUT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         seq_ff  <= 1'b0;
      end else if (fire) begin
         busy_ff <= busy_in;
         seq_ff  <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         held_payload_ff <= held_payload_in;
         held_sum_ff     <= held_sum_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/abs_checker.sv */
`default_nettype none
module abs_checker import abs_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_send_valid,
   input wire logic        rsp_send_seq,
   input wire logic [6:0]  rsp_send_ack_field,
   input wire logic [12:0] rsp_send_sum,
   input wire logic        rsp_timer_start,
   input wire logic        rsp_timer_stop,
   input wire logic [2:0]  rsp_status
);

   // a sent packet always carries the fixed ack code
   a_ack_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_valid |-> rsp_send_ack_field == SEND_ACK_CODE)
      else $error("sent packet with wrong ack field");

   // no packet means empty packet fields
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_send_valid |->
         !rsp_send_seq && rsp_send_ack_field == '0 && rsp_send_sum == '0)
      else $error("packet fields set without a send");

   // timer start goes with a send or a resend, and only then
   a_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_timer_start ==
         (rsp_status == ST_SENT || rsp_status == ST_RESENT))
      else $error("timer start does not match status");

   // timer stop goes with an accepted ack only
   a_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_timer_stop == (rsp_status == ST_ACK_ACCEPTED))
      else $error("timer stop does not match status");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("stalled result changed");

endmodule

bind alternating_bit_sender abs_checker u_abs_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_send_valid     (rsp_send_valid),
   .rsp_send_seq       (rsp_send_seq),
   .rsp_send_ack_field (rsp_send_ack_field),
   .rsp_send_sum       (rsp_send_sum),
   .rsp_timer_start    (rsp_timer_start),
   .rsp_timer_stop     (rsp_timer_stop),
   .rsp_status         (rsp_status)
);
`default_nettype wire

/* tb/alternating_bit_sender_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module alternating_bit_sender_checker import abs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [63:0] req_payload_w0,
   input  wire logic [63:0] req_payload_w1,
   input  wire logic [31:0] req_payload_w2,
   input  wire logic [19:0] req_ack_seq_field,
   input  wire logic [19:0] req_ack_number,
   input  wire logic [21:0] req_ack_sum,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_send_valid,
   input  wire logic        rsp_send_seq,
   input  wire logic [6:0]  rsp_send_ack_field,
   input  wire logic [12:0] rsp_send_sum,
   input  wire logic [63:0] rsp_send_w0,
   input  wire logic [63:0] rsp_send_w1,
   input  wire logic [31:0] rsp_send_w2,
   input  wire logic        rsp_timer_start,
   input  wire logic        rsp_timer_stop,
   input  wire logic [2:0]  rsp_status,
   output int               fail_count,
   output int               outstanding
);

   typedef struct packed {
      logic        send_valid;
      logic        send_seq;
      logic [6:0]  ack_field;
      logic [12:0] sum;
      logic [63:0] w0;
      logic [63:0] w1;
      logic [31:0] w2;
      logic        timer_start;
      logic        timer_stop;
      status_type  status;
   } sender_result_type;

   logic              busy = 1'b0;
   logic              seq_bit = 1'b0;
   logic [159:0]      held_payload = '0;
   logic [12:0]       held_sum = '0;
   sender_result_type expected_results[$];

   function automatic int sum_bytes(input logic [159:0] p);
      int s;
      s = 0;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         s += p[8*i +: 8];
      end
      return s;
   endfunction

   function automatic sender_result_type held_packet();
      sender_result_type r;
      r = '0;
      r.send_valid  = 1'b1;
      r.send_seq    = seq_bit;
      r.ack_field   = SEND_ACK_CODE;
      r.sum         = held_sum;
      r.w0          = held_payload[63:0];
      r.w1          = held_payload[127:64];
      r.w2          = held_payload[159:128];
      r.timer_start = 1'b1;
      return r;
   endfunction

   function automatic sender_result_type predict_event(input logic [1:0] func,
                                                       input logic [159:0] payload,
                                                       input logic [19:0] seqf,
                                                       input logic [19:0] ackn,
                                                       input logic [21:0] given);
      sender_result_type r;
      int calc;
      r = '0;
      case (func)
         FUNC_MESSAGE: begin
            if (busy) begin
               r.status = ST_DROPPED_BUSY;
            end else begin
               held_payload = '0;
               for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                  held_payload[8*i +: 8] = payload[8*i +: 8];
               end
               held_sum = 13'(sum_bytes(held_payload) + int'(seq_bit) + int'(SEND_ACK_CODE));
               busy = 1'b1;
               r = held_packet();
               r.status = ST_SENT;
            end
         end
         FUNC_ACK: begin
            calc = sum_bytes(payload) + int'(seqf) + int'(ackn);
            if (calc != int'(given)) begin
               r.status = ST_ACK_CORRUPT;
            end else if (!busy || ackn != 20'(seq_bit)) begin
               r.status = ST_ACK_UNEXPECT;
            end else begin
               seq_bit = ~seq_bit;
               busy = 1'b0;
               r.timer_stop = 1'b1;
               r.status = ST_ACK_ACCEPTED;
            end
         end
         FUNC_TIMEOUT: begin
            if (busy) begin
               r = held_packet();
               r.status = ST_RESENT;
            end else begin
               r.status = ST_IDLE_TIMEOUT;
            end
         end
         default: begin
            r.status = ST_IDLE_TIMEOUT;
         end
      endcase
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      sender_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(predict_event(req_func,
               {req_payload_w2, req_payload_w1, req_payload_w0},
               req_ack_seq_field, req_ack_number, req_ack_sum));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result transfer with nothing expected, expected none, actual status %0d",
                        $time, rsp_status);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("send_valid", 64'(want.send_valid), 64'(rsp_send_valid));
               check_field("send_seq", 64'(want.send_seq), 64'(rsp_send_seq));
               check_field("send_ack_field", 64'(want.ack_field), 64'(rsp_send_ack_field));
               check_field("send_sum", 64'(want.sum), 64'(rsp_send_sum));
               check_field("send_w0", want.w0, rsp_send_w0);
               check_field("send_w1", want.w1, rsp_send_w1);
               check_field("send_w2", 64'(want.w2), 64'(rsp_send_w2));
               check_field("timer_start", 64'(want.timer_start), 64'(rsp_timer_start));
               check_field("timer_stop", 64'(want.timer_stop), 64'(rsp_timer_stop));
               check_field("status", 64'(want.status), 64'(rsp_status));
            end
         end
      end
      outstanding <= expected_results.size();
   end

endmodule
`default_nettype wire

/* tb/alternating_bit_sender_tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module alternating_bit_sender_tb import abs_pkg::*; ();

   localparam logic [1:0] FUNC_UNDEFINED = 2'd3;
   localparam int         RANDOM_ITEMS   = 1100;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = '0;
   logic [63:0] req_payload_w0 = '0;
   logic [63:0] req_payload_w1 = '0;
   logic [31:0] req_payload_w2 = '0;
   logic [19:0] req_ack_seq_field = '0;
   logic [19:0] req_ack_number = '0;
   logic [21:0] req_ack_sum = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_send_valid;
   logic        rsp_send_seq;
   logic [6:0]  rsp_send_ack_field;
   logic [12:0] rsp_send_sum;
   logic [63:0] rsp_send_w0;
   logic [63:0] rsp_send_w1;
   logic [31:0] rsp_send_w2;
   logic        rsp_timer_start;
   logic        rsp_timer_stop;
   logic [2:0]  rsp_status;
   int          fail_count;
   int          outstanding;

   bit          calm = 1'b0;
   int          issued = 0;
   int          stall_left = 0;

   alternating_bit_sender dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_payload_w0     (req_payload_w0),
      .req_payload_w1     (req_payload_w1),
      .req_payload_w2     (req_payload_w2),
      .req_ack_seq_field  (req_ack_seq_field),
      .req_ack_number     (req_ack_number),
      .req_ack_sum        (req_ack_sum),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_send_valid     (rsp_send_valid),
      .rsp_send_seq       (rsp_send_seq),
      .rsp_send_ack_field (rsp_send_ack_field),
      .rsp_send_sum       (rsp_send_sum),
      .rsp_send_w0        (rsp_send_w0),
      .rsp_send_w1        (rsp_send_w1),
      .rsp_send_w2        (rsp_send_w2),
      .rsp_timer_start    (rsp_timer_start),
      .rsp_timer_stop     (rsp_timer_stop),
      .rsp_status         (rsp_status)
   );

   alternating_bit_sender_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_payload_w0     (req_payload_w0),
      .req_payload_w1     (req_payload_w1),
      .req_payload_w2     (req_payload_w2),
      .req_ack_seq_field  (req_ack_seq_field),
      .req_ack_number     (req_ack_number),
      .req_ack_sum        (req_ack_sum),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_send_valid     (rsp_send_valid),
      .rsp_send_seq       (rsp_send_seq),
      .rsp_send_ack_field (rsp_send_ack_field),
      .rsp_send_sum       (rsp_send_sum),
      .rsp_send_w0        (rsp_send_w0),
      .rsp_send_w1        (rsp_send_w1),
      .rsp_send_w2        (rsp_send_w2),
      .rsp_timer_start    (rsp_timer_start),
      .rsp_timer_stop     (rsp_timer_stop),
      .rsp_status         (rsp_status),
      .fail_count         (fail_count),
      .outstanding        (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // result side back-pressure: mostly short bursts, now and then a long hold
   always @(posedge clock) begin
      int r;
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            rsp_stall <= 1'b0;
            stall_left = $urandom_range(0, 6);
         end else begin
            rsp_stall <= 1'b1;
            stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
         end
      end
   end

   function automatic int idle_cycles();
      int r;
      if (calm) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [159:0] random_payload();
      return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
   endfunction

   function automatic logic [21:0] ack_checksum(input logic [159:0] p,
                                                input logic [19:0] seqf,
                                                input logic [19:0] ackn);
      int s;
      s = int'(seqf) + int'(ackn);
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         s += p[8*i +: 8];
      end
      return 22'(s);
   endfunction

   // drive one event and hold it until the transfer, then idle for a random gap that may be zero
   task automatic push_event(input logic [1:0] func, input logic [159:0] p,
                             input logic [19:0] seqf, input logic [19:0] ackn,
                             input logic [21:0] sum);
      int gap;
      req_valid         <= 1'b1;
      req_func          <= func;
      req_payload_w0    <= p[63:0];
      req_payload_w1    <= p[127:64];
      req_payload_w2    <= p[159:128];
      req_ack_seq_field <= seqf;
      req_ack_number    <= ackn;
      req_ack_sum       <= sum;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      issued++;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic push_ack(input logic [159:0] p, input logic [19:0] seqf,
                           input logic [19:0] ackn, input bit corrupt);
      logic [21:0] s;
      s = ack_checksum(p, seqf, ackn);
      if (corrupt) begin
         s ^= 22'($urandom_range(1, 22'h3FFFFF));
      end
      push_event(FUNC_ACK, p, seqf, ackn, s);
   endtask

   initial begin
      logic [159:0] ones;
      logic [159:0] p;
      bit           first;
      ones = '1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: idle cases, then three full rounds that cover both sequence values
      push_event(FUNC_TIMEOUT, '0, '0, '0, '0);
      push_event(FUNC_UNDEFINED, ones, '1, '1, '1);
      push_ack(ones, 20'h12345, 20'd0, 1'b0);
      push_event(FUNC_MESSAGE, ones, '0, '0, '0);
      push_event(FUNC_MESSAGE, random_payload(), '0, '0, '0);
      push_event(FUNC_TIMEOUT, random_payload(), '1, '1, '1);
      push_event(FUNC_UNDEFINED, '0, '0, '0, '0);
      push_ack(random_payload(), 20'($urandom()), 20'd0, 1'b1);
      push_ack(ones, 20'hFFFFF, 20'hFFFFF, 1'b0);
      push_ack(random_payload(), 20'($urandom()), 20'd1, 1'b0);
      push_ack('0, '0, 20'd0, 1'b0);
      push_event(FUNC_MESSAGE, '0, '0, '0, '0);
      push_event(FUNC_TIMEOUT, '0, '0, '0, '0);
      push_ack(random_payload(), 20'($urandom()), 20'd0, 1'b0);
      push_ack(ones, '0, 20'd1, 1'b1);
      push_ack(random_payload(), 20'($urandom()), 20'd1, 1'b0);
      push_ack(random_payload(), 20'($urandom()), 20'd1, 1'b0);
      push_event(FUNC_TIMEOUT, ones, '0, '0, '0);
      push_event(FUNC_MESSAGE, {20{8'hA5}}, '0, '0, '0);
      push_ack({20{8'h5A}}, 20'hFFFFF, 20'd0, 1'b0);

      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         if ($urandom_range(0, 19) == 0) begin
            calm = ~calm;
         end
         if ($urandom_range(0, 99) < 80) begin
            // a round: message, up to four disturbing events, then an ack for one number and usually for the other
            p = random_payload();
            push_event(FUNC_MESSAGE, p, 20'($urandom()), 20'($urandom()), 22'($urandom()));
            repeat ($urandom_range(0, 4)) begin
               case ($urandom_range(0, 3))
                  0: push_event(FUNC_TIMEOUT, random_payload(), 20'($urandom()),
                                20'($urandom()), 22'($urandom()));
                  1: push_event(FUNC_MESSAGE, random_payload(), '0, '0, '0);
                  2: push_ack(random_payload(), 20'($urandom()),
                              20'($urandom_range(0, 1)), 1'b1);
                  default: push_ack(random_payload(), 20'($urandom()),
                                    20'($urandom_range(2, 20'hFFFFF)), 1'b0);
               endcase
            end
            first = 1'($urandom_range(0, 1));
            push_ack(random_payload(), 20'($urandom()), 20'(first), 1'b0);
            if ($urandom_range(0, 3) != 0) begin
               push_ack(random_payload(), 20'($urandom()), 20'(!first), 1'b0);
            end
         end else begin
            logic [19:0] seqf;
            logic [19:0] ackn;
            p = random_payload();
            seqf = 20'($urandom());
            ackn = $urandom_range(0, 1) ? 20'($urandom_range(0, 1)) : 20'($urandom());
            push_event(2'($urandom_range(0, 3)), p, seqf, ackn,
                       $urandom_range(0, 1) ? ack_checksum(p, seqf, ackn) : 22'($urandom()));
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
`default_nettype wire
